FILE: hdl/expiring_token_table_defines.svh
// Assertion macros shared by the checker of the expiring token table.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef EXPIRING_TOKEN_TABLE_DEFINES_SVH
`define EXPIRING_TOKEN_TABLE_DEFINES_SVH

`define ETT_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle implication failed.");

`define ETT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle implication failed.");

`endif

FILE: hdl/ett_pkg.sv
// Shared types and constants of the expiring token table.
// No dependencies; the interfaces, controller, datapath, top level and checker use this package.
`default_nettype none

package ett_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int KEY_BITS_DEF = 25;

    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int EXP_W    = 33;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [OP_W-1:0]     opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam opcode_t OP_GENERATE = 2'd0;
    localparam opcode_t OP_RENEW    = 2'd1;
    localparam opcode_t OP_COUNT    = 2'd2;

    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_IGNORED = 2'd1;
    localparam status_t ST_FULL    = 2'd2;

    typedef struct packed {
        logic idle;
        logic clear_step;
        logic scan_step;
        logic commit;
    } ett_cmd_t;

    typedef struct packed {
        logic accepted;
        logic clear_last;
        logic scan_last;
        logic out_busy;
    } ett_stat_t;

endpackage

`default_nettype wire

FILE: hdl/ett_if.sv
// Channel interfaces of the expiring token table: request, response and configuration.
// Depends on ett_pkg for field widths.
`default_nettype none

interface ett_req_if #(
    parameter int KEY_BITS = ett_pkg::KEY_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [ett_pkg::OP_W-1:0]    opcode;
    logic [KEY_BITS-1:0]         token_key;
    logic [ett_pkg::TIME_W-1:0]  current_time;

    modport source (output valid, opcode, token_key, current_time, input ready);
    modport sink (input valid, opcode, token_key, current_time, output ready);
endinterface

interface ett_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ett_pkg::STATUS_W-1:0]  status;
    logic [ett_pkg::COUNT_W-1:0]   live_count;

    modport source (output valid, status, live_count, input ready);
    modport sink (input valid, status, live_count, output ready);
endinterface

interface ett_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ett_pkg::TIME_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/ett_ctrl.sv
// Controller of the expiring token table: clearing pass, table scan and commit sequencing.
// Depends on ett_pkg for the command and status structs.
`default_nettype none

module ett_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  ett_pkg::ett_stat_t stat,
    output ett_pkg::ett_cmd_t  cmd
);
    import ett_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_COMMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (stat.accepted)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.idle       = (state_reg == S_IDLE);
    assign cmd.clear_step = (state_reg == S_CLEAR);
    assign cmd.scan_step  = (state_reg == S_SCAN);
    assign cmd.commit     = (state_reg == S_COMMIT) && !stat.out_busy;

endmodule

`default_nettype wire

FILE: hdl/ett_datapath.sv
// Datapath of the expiring token table: slot memory, scan accumulators and result register.
// Depends on ett_pkg and the channel interfaces in ett_if.sv.
`default_nettype none

module ett_datapath #(
    parameter int ENTRIES  = ett_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = ett_pkg::KEY_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    ett_req_if.sink            req,
    ett_rsp_if.source          rsp,
    ett_cfg_if.sink            cfg,
    input  ett_pkg::ett_cmd_t  cmd,
    output ett_pkg::ett_stat_t stat
);
    import ett_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int WORD_W = 1 + KEY_BITS + EXP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [WORD_W-1:0] mem_array [ENTRIES];

    logic [TIME_W-1:0]   ttl_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic [IDX_W-1:0]    addr_next;
    logic                chk_vld_reg;
    logic [IDX_W-1:0]    chk_idx_reg;
    logic [WORD_W-1:0]   rd_word_reg;
    opcode_t             op_reg;
    opcode_t             op_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   now_next;
    logic                dup_reg;
    logic                dup_next;
    logic                found_reg;
    logic                found_next;
    logic [IDX_W-1:0]    found_idx_reg;
    logic [IDX_W-1:0]    found_idx_next;
    logic [COUNT_W-1:0]  cnt_reg;
    logic [COUNT_W-1:0]  cnt_next;
    logic                rsp_vld_reg;
    logic                rsp_vld_next;
    status_t             rsp_status_reg;
    status_t             rsp_status_next;
    logic [COUNT_W-1:0]  rsp_count_reg;
    logic [COUNT_W-1:0]  rsp_count_next;

    logic                accept;
    logic                rd_valid;
    logic [KEY_BITS-1:0] rd_key;
    logic [EXP_W-1:0]    rd_exp;
    logic                live;
    logic                key_hit;
    logic [EXP_W-1:0]    expiry;
    logic                commit_wr;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;

    assign accept   = req.valid && req.ready;
    assign rd_valid = rd_word_reg[WORD_W-1];
    assign rd_key   = rd_word_reg[WORD_W-2 -: KEY_BITS];
    assign rd_exp   = rd_word_reg[EXP_W-1:0];
    assign live     = chk_vld_reg && rd_valid && (rd_exp > {1'b0, now_reg});
    assign key_hit  = (rd_key == key_reg);
    assign expiry   = {1'b0, now_reg} + {1'b0, ttl_reg};

    assign commit_wr = ((op_reg == OP_GENERATE) && !dup_reg && found_reg)
                    || ((op_reg == OP_RENEW) && found_reg);

    always_comb
    begin
        addr_next       = addr_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        dup_next        = dup_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        cnt_next        = cnt_reg;
        rsp_vld_next    = rsp_vld_reg;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;

        if (cmd.clear_step || cmd.scan_step)
        begin
            addr_next = (addr_reg == LAST_IDX) ? '0 : addr_reg + IDX_W'(1);
        end

        if (accept)
        begin
            op_next        = req.opcode;
            key_next       = req.token_key;
            now_next       = req.current_time;
            dup_next       = 1'b0;
            found_next     = 1'b0;
            found_idx_next = '0;
            cnt_next       = '0;
        end
        else if (chk_vld_reg)
        begin
            unique case (op_reg)
                OP_GENERATE:
                begin
                    if (live && key_hit)
                    begin
                        dup_next = 1'b1;
                    end
                    else if (!live && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = chk_idx_reg;
                    end
                end
                OP_RENEW:
                begin
                    if (live && key_hit && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = chk_idx_reg;
                    end
                end
                OP_COUNT:
                begin
                    if (live && (cnt_reg != COUNT_MAX))
                    begin
                        cnt_next = cnt_reg + COUNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.commit)
        begin
            rsp_vld_next   = 1'b1;
            rsp_count_next = '0;
            unique case (op_reg)
                OP_GENERATE:
                begin
                    if (dup_reg)
                    begin
                        rsp_status_next = ST_IGNORED;
                    end
                    else if (!found_reg)
                    begin
                        rsp_status_next = ST_FULL;
                    end
                    else
                    begin
                        rsp_status_next = ST_DONE;
                    end
                end
                OP_RENEW:
                begin
                    rsp_status_next = found_reg ? ST_DONE : ST_IGNORED;
                end
                OP_COUNT:
                begin
                    rsp_status_next = ST_DONE;
                    rsp_count_next  = cnt_reg;
                end
                default:
                begin
                    rsp_status_next = ST_IGNORED;
                end
            endcase
        end
        else if (rsp.ready)
        begin
            rsp_vld_next = 1'b0;
        end
    end

    assign mem_we    = cmd.clear_step || (cmd.commit && commit_wr);
    assign mem_waddr = cmd.clear_step ? addr_reg : found_idx_reg;
    assign mem_wdata = cmd.clear_step ? '0 : {1'b1, key_reg, expiry};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (cmd.scan_step)
        begin
            rd_word_reg <= mem_array[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg     <= TIME_W'(1);
            addr_reg    <= '0;
            chk_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                ttl_reg <= cfg.data;
            end
            addr_reg    <= addr_next;
            chk_vld_reg <= cmd.scan_step;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= addr_reg;
        op_reg         <= op_next;
        key_reg        <= key_next;
        now_reg        <= now_next;
        dup_reg        <= dup_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        cnt_reg        <= cnt_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
    end

    assign req.ready      = cmd.idle;
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = rsp_vld_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.live_count = rsp_count_reg;

    assign stat.accepted   = accept;
    assign stat.clear_last = (addr_reg == LAST_IDX);
    assign stat.scan_last  = (addr_reg == LAST_IDX);
    assign stat.out_busy   = rsp_vld_reg && !rsp.ready;

endmodule

`default_nettype wire

FILE: hdl/expiring_token_table.sv
// Top level of the expiring token table: controller plus slot datapath.
// Depends on ett_pkg, ett_if.sv, ett_ctrl and ett_datapath.
//
// Every request, whatever its opcode, reads all ENTRIES slots through the single read
// port of the slot memory, one slot per cycle, then passes through a drain state for
// the last read and a commit state for the write-back; no new request is taken until
// the previous one has been committed. A result that is still waiting in the response
// register holds the next request in its commit step, not at its scan. After reset the
// block runs a clearing pass over all ENTRIES slots with its request ready low;
// time_to_live writes are accepted at any time and reset to one.
`default_nettype none

module expiring_token_table #(
    parameter int ENTRIES  = ett_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = ett_pkg::KEY_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ett_req_if.sink   req,
    ett_rsp_if.source rsp,
    ett_cfg_if.sink   cfg
);
    import ett_pkg::*;

    ett_cmd_t  cmd;
    ett_stat_t stat;

    ett_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    ett_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

`default_nettype wire

FILE: hdl/ett_checker.sv
// Port-level checker of the expiring token table and its bind to the top level.
// Depends on ett_pkg and the macros in expiring_token_table_defines.svh.
`default_nettype none

`include "expiring_token_table_defines.svh"

module ett_port_checker #(
    parameter int ENTRIES = ett_pkg::ENTRIES_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [ett_pkg::STATUS_W-1:0] rsp_status,
    input logic [ett_pkg::COUNT_W-1:0]  rsp_live_count
);
    import ett_pkg::*;

    `ETT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `ETT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
    `ETT_ASSERT_IMPLIES(a_count_only_done, rsp_valid && (rsp_live_count != '0), rsp_status == ST_DONE)
    `ETT_ASSERT_IMPLIES(a_count_bound, rsp_valid, int'(rsp_live_count) <= ENTRIES)

endmodule

bind expiring_token_table ett_port_checker #(
    .ENTRIES (ENTRIES)
) u_ett_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_live_count (rsp.live_count)
);

`default_nettype wire
